[rtl/core/ring_frame_extractor_top_assert.svh]
// Assertion macros for the ring frame extractor RTL.
`ifndef RING_FRAME_EXTRACTOR_TOP_ASSERT_SVH
`define RING_FRAME_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define RFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by reset.
`define RFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rfe_pkg.sv]
// Package: sizes, command codes, payload structs and sequencer states of the frame extractor.
package rfe_pkg;

    localparam int RING_SIZE   = 4096;
    localparam int RING_AW     = $clog2(RING_SIZE);
    localparam int SCAN_DEPTH  = 1000;
    localparam int OFF_W       = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
    localparam int STAGE_DEPTH = 255;
    localparam int STAGE_AW    = 8;
    localparam int FRAME_EXTRA = 260;
    localparam int BACK_W      = $clog2(SCAN_DEPTH + FRAME_EXTRA);
    localparam int CNT_W       = 9;
    localparam int MAX_CHANNEL = 25;
    localparam int PADDR_W     = 3;

    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_LINK_EN = 3'd0;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [4:0] channel;
        logic [7:0] payload_index;
    } t_rfe_in;

    typedef struct packed {
        logic       found;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
    } t_rfe_out;

    typedef struct packed {
        logic     valid;
        t_rfe_out data;
    } t_rfe_res;

    typedef enum logic [13:0] {
        S_INIT = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_DONE = 14'b00000000000100,
        S_STG  = 14'b00000000001000,
        S_R1   = 14'b00000000010000,
        S_R2   = 14'b00000000100000,
        S_R3   = 14'b00000001000000,
        S_R4   = 14'b00000010000000,
        S_R5   = 14'b00000100000000,
        S_R6   = 14'b00001000000000,
        S_CPR  = 14'b00010000000000,
        S_CPW  = 14'b00100000000000,
        S_ZERO = 14'b01000000000000,
        S_SKIP = 14'b10000000000000
    } t_rfe_state;

endpackage

[rtl/core/rfe_apb_regs.sv]
// APB configuration register block holding the link enable.
module rfe_apb_regs
    import rfe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic               o_link_en
);

    logic r_link_en;
    logic n_link_en;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_link_en = r_link_en;
        if (wr_en && (paddr == ADDR_LINK_EN)) begin
            n_link_en = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_en <= 1'b0;
        end else begin
            r_link_en <= n_link_en;
        end
    end

    assign prdata    = (paddr == ADDR_LINK_EN) ? {31'd0, r_link_en} : 32'd0;
    assign o_link_en = r_link_en;

endmodule

[rtl/core/rfe_ctrl.sv]
// Sequencer with ring and staging memories, shared address adder and marker comparator.
`include "ring_frame_extractor_top_assert.svh"
module rfe_ctrl
    import rfe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_link_en,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_rfe_in  i_in_data,
    output t_rfe_res o_res,
    input  logic     i_res_ready
);

    t_rfe_state r_state;
    t_rfe_state n_state;

    logic [RING_AW-1:0]  r_wp;
    logic [RING_AW-1:0]  r_clr;
    logic [OFF_W-1:0]    r_off;
    logic [7:0]          r_base;
    logic [7:0]          r_len;
    logic [CNT_W-1:0]    r_cnt;
    logic [7:0]          r_rdata;
    logic [7:0]          r_stage_rdata;
    t_rfe_out            r_res;

    logic [7:0]          ring_mem [RING_SIZE];
    logic [7:0]          stage_mem [STAGE_DEPTH];

    logic                in_fire;
    logic [CNT_W-1:0]    extra;
    logic [BACK_W-1:0]   back;
    logic [RING_AW-1:0]  scan_addr;
    logic [RING_AW-1:0]  ring_addr;
    logic                ring_we;
    logic [7:0]          ring_wdata;
    logic [1:0]          cmp_k;
    logic                cmp_hit;
    logic                stage_re;
    logic                stage_we;
    logic                last_off;
    logic [CNT_W-1:0]    base_wide;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign last_off   = (r_off == OFF_W'(SCAN_DEPTH - 1));

    always_comb begin
        case (r_state)
            S_R1:    extra = CNT_W'(1);
            S_R2:    extra = CNT_W'(2);
            S_R3:    extra = CNT_W'(3);
            S_R4:    extra = CNT_W'(r_rdata) + CNT_W'(4);
            S_R5:    extra = CNT_W'(r_len) + CNT_W'(5);
            S_CPR:   extra = CNT_W'(r_len) + CNT_W'(3) - r_cnt;
            S_ZERO:  extra = r_cnt + CNT_W'(1);
            default: extra = '0;
        endcase
    end

    assign back      = BACK_W'(r_off) + BACK_W'(extra);
    assign scan_addr = r_wp - RING_AW'(back);

    always_comb begin
        case (r_state)
            S_R2:    cmp_k = 2'd3;
            S_R3:    cmp_k = 2'd2;
            S_R5:    cmp_k = 2'd1;
            default: cmp_k = 2'd0;
        endcase
    end

    assign cmp_hit   = (r_rdata == (r_base + 8'(cmp_k)));
    assign base_wide = {i_in_data.channel, 3'b000} + {3'b000, i_in_data.channel, 1'b0};

    always_comb begin
        ring_addr  = scan_addr;
        ring_we    = 1'b0;
        ring_wdata = 8'd0;
        case (r_state)
            S_INIT: begin
                ring_addr = r_clr;
                ring_we   = 1'b1;
            end
            S_IDLE: begin
                if (in_fire && (i_in_data.command == CMD_PUSH)) begin
                    ring_addr  = r_wp;
                    ring_we    = 1'b1;
                    ring_wdata = i_in_data.rx_byte;
                end
            end
            S_ZERO: begin
                ring_we = 1'b1;
            end
            default: begin
                ring_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[ring_addr] <= ring_wdata;
        end
        r_rdata <= ring_mem[ring_addr];
    end

    assign stage_re = in_fire && (i_in_data.command == CMD_READ) &&
                      (i_in_data.payload_index < 8'(STAGE_DEPTH));
    assign stage_we = (r_state == S_CPW);

    always_ff @(posedge i_clk) begin
        if (stage_we) begin
            stage_mem[r_cnt[STAGE_AW-1:0]] <= r_rdata;
        end
        if (stage_re) begin
            r_stage_rdata <= stage_mem[i_in_data.payload_index];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_data.command)
                        CMD_EXTRACT: begin
                            if (i_link_en && (i_in_data.channel <= 5'(MAX_CHANNEL))) begin
                                n_state = S_R1;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        CMD_READ: begin
                            n_state = stage_re ? S_STG : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_STG:  n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_R1:   n_state = S_R2;
            S_R2:   n_state = cmp_hit ? S_R3 : S_SKIP;
            S_R3:   n_state = cmp_hit ? S_R4 : S_SKIP;
            S_R4:   n_state = S_R5;
            S_R5:   n_state = cmp_hit ? S_R6 : S_SKIP;
            S_R6: begin
                if (!cmp_hit) begin
                    n_state = S_SKIP;
                end else if (r_len == 8'd0) begin
                    n_state = S_ZERO;
                end else begin
                    n_state = S_CPR;
                end
            end
            S_SKIP: n_state = last_off ? S_DONE : S_R1;
            S_CPR:  n_state = S_CPW;
            S_CPW:  n_state = (r_cnt == CNT_W'(r_len) - CNT_W'(1)) ? S_ZERO : S_CPR;
            S_ZERO: begin
                if (r_cnt == CNT_W'(r_len) + CNT_W'(4)) begin
                    n_state = S_DONE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_wp    <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) begin
                r_clr <= r_clr + RING_AW'(1);
            end
            if (in_fire && (i_in_data.command == CMD_PUSH)) begin
                r_wp <= r_wp + RING_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_res  <= '0;
                r_off  <= '0;
                r_cnt  <= '0;
                r_base <= base_wide[7:0];
            end
            S_STG:  r_res.payload_byte <= r_stage_rdata;
            S_R4:   r_len <= r_rdata;
            S_R6:   r_cnt <= '0;
            S_SKIP: begin
                if (!last_off) begin
                    r_off <= r_off + OFF_W'(1);
                end
            end
            S_CPW: begin
                if (r_cnt == CNT_W'(r_len) - CNT_W'(1)) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            S_ZERO: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(r_len) + CNT_W'(4)) begin
                    r_res.found          <= 1'b1;
                    r_res.payload_length <= r_len;
                end
            end
            default: begin
                r_off <= r_off;
            end
        endcase
    end

    assign o_res.valid = (r_state == S_DONE);
    assign o_res.data  = r_res;

    `RFE_ASSERT_NEXT(a_push_advance, i_clk, i_rst_n, in_fire && (i_in_data.command == CMD_PUSH), r_wp == $past(r_wp) + RING_AW'(1), "push did not advance write position")
    `RFE_ASSERT_NOW(a_off_range, i_clk, i_rst_n, r_state != S_INIT && r_state != S_IDLE, r_off <= OFF_W'(SCAN_DEPTH - 1), "scan offset out of range")
    `RFE_ASSERT_NOW(a_copy_range, i_clk, i_rst_n, r_state == S_CPW, r_cnt < CNT_W'(r_len), "copy index beyond frame length")
    `RFE_ASSERT_NOW(a_found_link, i_clk, i_rst_n, r_state == S_DONE && r_res.found, i_link_en, "frame found with link disabled")

endmodule

[rtl/core/ring_frame_extractor_top.sv]
// Ring frame extractor: push, extract and read requests with an output register.
// Push, read, unknown and disabled or out-of-range extract requests skip the scan; one request at a time.
// Extract: scans up to 1000 offsets, one offset after another, through one ring port;
//   a match reads the markers and length, then copies the payload and clears the frame in the ring.
// Reset is synchronous, active low; a clearing pass over the whole ring follows,
//   during which no request is taken (configuration writes are).
module ring_frame_extractor_top
    import rfe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_rfe_in            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_rfe_out           o_out_data
);

    logic     link_en;
    t_rfe_res res;
    logic     res_ready;
    logic     r_out_valid;
    t_rfe_out r_out_data;

    rfe_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_link_en (link_en)
    );

    rfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_link_en   (link_en),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_data <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[bench/tb_ring_frame_extractor_top.sv]
// Self-checking bench for ring_frame_extractor_top: directed and random requests against a ring predictor.
module tb_ring_frame_extractor_top
    import rfe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int ITEM_TARGET = 950;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = 50;
    localparam int TOP_CHANNEL = 31;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_rfe_in            in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_rfe_out           out_data;

    logic [7:0]         ring_mem [RING_SIZE];
    logic [RING_AW-1:0] wr_pos;
    logic [7:0]         stage_mem [STAGE_DEPTH];
    int                 stage_hi;
    logic               link_on;
    t_rfe_out           replies_due [$];

    int  items_sent = 0;
    int  faults = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    int  hold_ticket = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    ring_frame_extractor_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 95) return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    function automatic int ring_back(input int back);
        return (int'(wr_pos) + RING_SIZE - (back % RING_SIZE)) % RING_SIZE;
    endfunction

    function automatic t_rfe_out ring_apply(input t_rfe_in req);
        t_rfe_out res;
        int base;
        int len;
        int i;
        int n;
        bit hit;
        res = '0;
        case (req.command)
            CMD_PUSH: begin
                ring_mem[wr_pos] = req.rx_byte;
                wr_pos = wr_pos + 1'b1;
            end
            CMD_EXTRACT: begin
                base = 10 * int'(req.channel);
                hit = 1'b0;
                if (link_on) begin
                    for (i = 0; i < SCAN_DEPTH && !hit; i++) begin
                        len = int'(ring_mem[ring_back(i + 3)]);
                        if (ring_mem[ring_back(i + 1)] == base + 3 &&
                            ring_mem[ring_back(i + 2)] == base + 2 &&
                            ring_mem[ring_back(i + len + 4)] == base + 1 &&
                            ring_mem[ring_back(i + len + 5)] == base) begin
                            hit = 1'b1;
                            for (n = 0; n < len && n < STAGE_DEPTH; n++)
                                stage_mem[n] = ring_mem[ring_back(i + len + 3 - n)];
                            ring_mem[ring_back(i + 1)] = '0;
                            ring_mem[ring_back(i + 2)] = '0;
                            ring_mem[ring_back(i + 3)] = '0;
                            ring_mem[ring_back(i + len + 4)] = '0;
                            ring_mem[ring_back(i + len + 5)] = '0;
                            for (n = 0; n < len; n++)
                                ring_mem[ring_back(i + len + 3 - n)] = '0;
                            if (len > stage_hi) stage_hi = len;
                            res.found = 1'b1;
                            res.payload_length = 8'(len);
                        end
                    end
                end
            end
            CMD_READ: begin
                if (req.payload_index < STAGE_DEPTH)
                    res.payload_byte = stage_mem[req.payload_index];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(negedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin : check_reply
        t_rfe_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (replies_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected reply: found=%0d len=%0d byte=%0d",
                             out_data.found, out_data.payload_length, out_data.payload_byte);
            end else begin
                want = replies_due.pop_front();
                if (out_data.found !== want.found ||
                    out_data.payload_length !== want.payload_length ||
                    out_data.payload_byte !== want.payload_byte) begin
                    faults++;
                    if (faults <= 10)
                        $display({"reply mismatch: expected found=%0d len=%0d byte=%0d, ",
                                  "got found=%0d len=%0d byte=%0d"},
                                 want.found, want.payload_length, want.payload_byte,
                                 out_data.found, out_data.payload_length,
                                 out_data.payload_byte);
                end
            end
        end
    end

    task automatic send_req(input t_rfe_in req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data <= req;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        replies_due.push_back(ring_apply(req));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle_replies();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (replies_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic link_write(input logic on);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_LINK_EN;
        pwdata <= 32'(on);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        link_on = on;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        psel <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[0] !== on) begin
            faults++;
            if (faults <= 10)
                $display("link_enabled readback: expected %0d, got %0d", on, prdata[0]);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_rfe_in req;
        req.command = CMD_PUSH;
        req.rx_byte = b;
        req.channel = 5'($urandom);
        req.payload_index = 8'($urandom);
        send_req(req);
    endtask

    task automatic extract_chan(input int ch);
        t_rfe_in req;
        req.command = CMD_EXTRACT;
        req.rx_byte = 8'($urandom);
        req.channel = 5'(ch);
        req.payload_index = 8'($urandom);
        send_req(req);
    endtask

    task automatic read_at(input int idx);
        t_rfe_in req;
        req.command = CMD_READ;
        req.rx_byte = 8'($urandom);
        req.channel = 5'($urandom);
        req.payload_index = 8'(idx);
        send_req(req);
    endtask

    // keep reads on staged entries that an extract has written, or past the store
    task automatic read_any();
        if (stage_hi == 0 || $urandom_range(0, 9) == 0)
            read_at(STAGE_DEPTH);
        else
            read_at($urandom_range(0, stage_hi - 1));
    endtask

    task automatic send_odd();
        t_rfe_in req;
        req.command = CMD_UNKNOWN;
        req.rx_byte = 8'($urandom);
        req.channel = 5'($urandom);
        req.payload_index = 8'($urandom);
        send_req(req);
    endtask

    task automatic send_frame(input int ch, input int len, input bit broken);
        logic [7:0] bytes [$];
        int k;
        int spot;
        bytes.push_back(8'(10 * ch));
        bytes.push_back(8'(10 * ch + 1));
        for (k = 0; k < len; k++) bytes.push_back(8'($urandom));
        bytes.push_back(8'(len));
        bytes.push_back(8'(10 * ch + 2));
        bytes.push_back(8'(10 * ch + 3));
        if (broken) begin
            spot = $urandom_range(0, bytes.size() - 1);
            if ($urandom_range(0, 1) == 0)
                bytes.delete(spot);
            else
                bytes[spot] = bytes[spot] ^ 8'($urandom_range(1, 255));
        end
        for (k = 0; k < bytes.size(); k++) push_byte(bytes[k]);
    endtask

    task automatic test_directed();
        t_rfe_in req;
        link_write(1'b0);
        send_frame(3, 2, 1'b0);
        extract_chan(3);
        settle_replies();
        link_write(1'b1);
        extract_chan(3);
        read_at(0);
        read_at(1);
        read_at(STAGE_DEPTH);
        send_frame(MAX_CHANNEL, 0, 1'b0);
        extract_chan(MAX_CHANNEL);
        extract_chan(TOP_CHANNEL);
        req.command = CMD_UNKNOWN;
        req.rx_byte = '1;
        req.channel = '1;
        req.payload_index = '1;
        send_req(req);
        push_byte(8'hff);
        push_byte(8'h00);
    endtask

    task automatic test_long_frame();
        int ch;
        ch = $urandom_range(0, MAX_CHANNEL);
        send_frame(ch, 255, 1'b0);
        extract_chan(ch);
        read_at(254);
        read_at(128);
        read_at(0);
        read_any();
        read_any();
        ch = $urandom_range(0, MAX_CHANNEL);
        send_frame(ch, 1, 1'b0);
        extract_chan(ch);
        read_at(200);
        read_at(0);
    endtask

    task automatic test_backpressure();
        int k;
        hold_ticket++;
        for (k = 0; k < 4; k++) begin
            send_frame(k + 7, 4, 1'b0);
            extract_chan(k + 7);
            read_any();
        end
        for (k = 0; k < 8; k++) push_byte(8'($urandom));
        settle_replies();
    endtask

    task automatic test_link_off();
        int ch;
        settle_replies();
        link_write(1'b0);
        ch = $urandom_range(0, MAX_CHANNEL);
        send_frame(ch, pick_len(), 1'b0);
        send_frame(ch, pick_len(), 1'b0);
        extract_chan(ch);
        extract_chan(ch);
        read_any();
        settle_replies();
        link_write(1'b1);
        extract_chan(ch);
        extract_chan(ch);
        read_any();
        read_any();
    endtask

    task automatic test_random();
        int pick;
        int nfr;
        int k;
        int ch;
        int chans [3];
        int quiet_until;
        quiet_until = items_sent + 120;
        quiet = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= quiet_until) quiet = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                nfr = $urandom_range(1, 3);
                for (k = 0; k < nfr; k++) begin
                    chans[k] = $urandom_range(0, MAX_CHANNEL);
                    send_frame(chans[k], pick_len(), 1'b0);
                end
                extract_chan(chans[$urandom_range(0, nfr - 1)]);
                if ($urandom_range(0, 4) == 0) extract_chan(chans[0]);
                for (k = $urandom_range(0, 3); k > 0; k--) read_any();
            end else if (pick < 60) begin
                ch = $urandom_range(0, MAX_CHANNEL);
                send_frame(ch, pick_len(), 1'b1);
                extract_chan(ch);
            end else if (pick < 78) begin
                for (k = $urandom_range(1, 6); k > 0; k--) push_byte(8'($urandom));
            end else if (pick < 91) begin
                for (k = $urandom_range(1, 4); k > 0; k--) read_any();
            end else if (pick < 96) begin
                send_odd();
            end else begin
                extract_chan($urandom_range(0, TOP_CHANNEL));
            end
        end
        quiet = 1'b0;
    endtask

    // channel 0 frame at the ring start: its first marker is the cleared top entry
    task automatic test_ring_wrap();
        int k;
        link_write(1'b1);
        push_byte(8'd1);
        for (k = 0; k < 3; k++) push_byte(8'($urandom));
        push_byte(8'd3);
        push_byte(8'd2);
        push_byte(8'd3);
        extract_chan(0);
        read_at(2);
        read_at(0);
        settle_replies();
    endtask

    initial begin
        for (int k = 0; k < RING_SIZE; k++) ring_mem[k] = '0;
        for (int k = 0; k < STAGE_DEPTH; k++) stage_mem[k] = '0;
        wr_pos = '0;
        stage_hi = 0;
        link_on = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_ring_wrap();
        test_directed();
        test_long_frame();
        test_backpressure();
        test_link_off();
        test_random();
        settle_replies();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (faults == 0 && replies_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
